### rtl/core/manchester_sync_frame_encoder_unit_macros.svh
// assertion macros for the manchester sync frame encoder
`ifndef MANCHESTER_SYNC_FRAME_ENCODER_UNIT_MACROS_SVH
`define MANCHESTER_SYNC_FRAME_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTH
`define MSFE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MSFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSFE_ASSERT(lbl, cond, msg)
`define MSFE_ASSERT_IMPL(lbl, ante, cons, msg)
`define MSFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/msfe_pkg.sv
// shared types and constants of the manchester sync frame encoder
`timescale 1ns / 1ps
package msfe_pkg;

  localparam int FPH_W      = 10;
  localparam int AMP_W      = 31;
  localparam int LEN_W      = 16;
  localparam int SAMPLE_W   = 32;
  localparam int WORD_W     = 32;
  localparam int FC_W       = 10;
  localparam int HBC_W      = 7;
  localparam int BP_W       = 5;
  localparam int SYNC_IDX_W = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 31;

  localparam int MESSAGE_BITS_DEF = 32;
  localparam int SYNC_LENGTH_DEF  = 5;

  localparam logic [FPH_W-1:0] FPH_RESET = 10'd40;
  localparam logic [AMP_W-1:0] AMP_RESET = 31'd2126008811;
  localparam logic [LEN_W-1:0] MIN_RESET = 16'hFFFF;

  // sync half-bit levels, entry 0 first: high, high, high, low, high, then low
  localparam logic [(1 << SYNC_IDX_W)-1:0] SYNC_LEVELS = 16'b0000_0000_0001_0111;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_HALF_BIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE           = 4'd1;

  typedef struct packed {
    logic [FPH_W-1:0] frames_per_half_bit;
    logic [AMP_W-1:0] amplitude;
  } cfg_t;

  typedef struct packed {
    logic level_high;
    logic in_sync;
  } level_t;

endpackage

### rtl/core/msfe_channels.sv
// request channel interfaces of the manchester sync frame encoder
`timescale 1ns / 1ps
interface msfe_in_if
  import msfe_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             buffer_start;
  logic [LEN_W-1:0] buffer_length;
  modport source (output valid, buffer_start, buffer_length, input ready);
  modport sink (input valid, buffer_start, buffer_length, output ready);
endinterface

interface msfe_out_if
  import msfe_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       level_high;
  logic                       in_sync;
  modport source (output valid, sample, level_high, in_sync, input ready);
  modport sink (input valid, sample, level_high, in_sync, output ready);
endinterface

interface msfe_cfg_if
  import msfe_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/msfe_cfg.sv
// configuration registers of the manchester sync frame encoder
`timescale 1ns / 1ps
module msfe_cfg
  import msfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  msfe_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  logic [FPH_W-1:0] fph_r;
  logic [AMP_W-1:0] amp_r;
  logic             wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fph_r <= FPH_RESET;
      amp_r <= AMP_RESET;
    end else if (wr) begin
      case (cfg_ch.index)
        CFG_FRAMES_PER_HALF_BIT: fph_r <= cfg_ch.data[FPH_W-1:0];
        CFG_AMPLITUDE:           amp_r <= cfg_ch.data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.frames_per_half_bit = fph_r;
  assign cfg.amplitude           = amp_r;

endmodule

### rtl/core/msfe_seq.sv
// frame and half-bit sequencer with message word and length tracking
`timescale 1ns / 1ps
`include "manchester_sync_frame_encoder_unit_macros.svh"
module msfe_seq
  import msfe_pkg::*;
#(
  parameter int MESSAGE_BITS = MESSAGE_BITS_DEF,
  parameter int SYNC_LENGTH  = SYNC_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [FPH_W-1:0] frames_per_half_bit,
  input  logic             step,
  input  logic             buffer_start,
  input  logic [LEN_W-1:0] buffer_length,
  output level_t           level
);

  localparam int HB_MSG = 2 * MESSAGE_BITS;
  localparam int HB_CYC = HB_MSG + SYNC_LENGTH;
  localparam logic [HBC_W-1:0] HB_MSG_C = HBC_W'(HB_MSG);
  localparam logic [HBC_W-1:0] HB_CYC_C = HBC_W'(HB_CYC);
  localparam logic [BP_W-1:0]  BP_MAX   = BP_W'(MESSAGE_BITS - 1);

  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [HBC_W-1:0]  hbc_r, hbc_nxt;
  logic [BP_W-1:0]   bp_r, bp_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              parity_r, parity_nxt;
  logic [LEN_W-1:0]  min_r, min_nxt;
  logic [LEN_W-1:0]  max_r, max_nxt;

  logic [FPH_W-1:0]      limit;
  logic [FC_W-1:0]       fc_inc;
  logic [HBC_W-1:0]      hbc_inc;
  logic [SYNC_IDX_W-1:0] sync_idx;
  logic                  fc_wrap;
  logic                  hbc_wrap;
  logic                  msg_bit;

  // current half-bit level
  always_comb begin
    msg_bit  = word_r[bp_r];
    sync_idx = SYNC_IDX_W'(hbc_r - HB_MSG_C);
    if (hbc_r < HB_MSG_C) begin
      level.in_sync    = 1'b0;
      level.level_high = (hbc_r[0] == msg_bit);
    end else begin
      level.in_sync    = 1'b1;
      level.level_high = SYNC_LEVELS[sync_idx];
    end
  end

  always_comb begin
    min_nxt    = min_r;
    max_nxt    = max_r;
    fc_nxt     = fc_r;
    hbc_nxt    = hbc_r;
    bp_nxt     = bp_r;
    word_nxt   = word_r;
    parity_nxt = parity_r;
    limit      = (frames_per_half_bit == '0) ? FPH_W'(1) : frames_per_half_bit;
    fc_inc     = fc_r + FC_W'(1);
    hbc_inc    = hbc_r + HBC_W'(1);
    fc_wrap    = (fc_inc >= limit) || (fc_inc == '0);
    hbc_wrap   = fc_wrap && (hbc_inc >= HB_CYC_C);
    if (step) begin
      if (buffer_start) begin
        if (buffer_length > max_r) max_nxt = buffer_length;
        if (buffer_length < min_r) min_nxt = buffer_length;
      end
      fc_nxt = fc_inc;
      if (fc_wrap) begin
        fc_nxt  = '0;
        hbc_nxt = hbc_inc;
        if (!hbc_inc[0] && bp_r != '0) bp_nxt = bp_r - BP_W'(1);
        if (hbc_wrap) begin
          hbc_nxt    = '0;
          bp_nxt     = BP_MAX;
          word_nxt   = parity_r ? WORD_W'(max_nxt) : WORD_W'(min_nxt);
          parity_nxt = !parity_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r     <= '0;
      hbc_r    <= '0;
      bp_r     <= '0;
      word_r   <= '0;
      parity_r <= 1'b0;
      min_r    <= MIN_RESET;
      max_r    <= '0;
    end else begin
      fc_r     <= fc_nxt;
      hbc_r    <= hbc_nxt;
      bp_r     <= bp_nxt;
      word_r   <= word_nxt;
      parity_r <= parity_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
    end
  end

  `MSFE_ASSERT(a_bp_range, bp_r <= BP_MAX, "bit position past message length")
  `MSFE_ASSERT(a_hbc_range, hbc_r < HB_CYC_C, "half-bit counter past cycle length")
  `MSFE_ASSERT_NEXT(a_hb_edge_clears_fc, step && fc_wrap, fc_r == '0, "frame count not cleared")
  `MSFE_ASSERT_NEXT(a_parity_toggle, step && hbc_wrap, parity_r != $past(parity_r), "no toggle")

endmodule

### rtl/core/manchester_sync_frame_encoder_unit.sv
// top level of the manchester sync frame encoder
// usage:
//   in_ch carries one request per audio frame: buffer_start and buffer_length.
//   out_ch returns one request per input: the Q31 sample (plus or minus the
//   amplitude), level_high and in_sync. cfg_ch writes frames_per_half_bit
//   (index 0) and amplitude (index 1); it is always ready, and the user must
//   write it only while the block is idle, which the block does not enforce.
// timing:
//   one result per input, registered, in the cycle after the input is taken.
//   throughput is one frame per cycle unless out_ch stalls; the frame and
//   half-bit counters and the message bit select step only on a taken frame.
// reset (synchronous, rst_n low): counters clear, the first message word is
//   zero, running min is 0xFFFF and max is 0, registers take their defaults,
//   and out_ch holds no result.
// stall: while a result waits on out_ch, in_ch is still ready if out_ch.ready
//   is high in the same cycle; otherwise in_ch waits and the result holds.
`timescale 1ns / 1ps
module manchester_sync_frame_encoder_unit
  import msfe_pkg::*;
#(
  parameter int MESSAGE_BITS = MESSAGE_BITS_DEF,
  parameter int SYNC_LENGTH  = SYNC_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  msfe_in_if.sink     in_ch,
  msfe_out_if.source  out_ch,
  msfe_cfg_if.sink    cfg_ch
);

  cfg_t   cfg;
  level_t level;
  logic   step;

  logic                       out_v_r;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                       high_r;
  logic                       sync_r;
  logic [SAMPLE_W-1:0]        amp_ext;

  msfe_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  msfe_seq #(
    .MESSAGE_BITS (MESSAGE_BITS),
    .SYNC_LENGTH  (SYNC_LENGTH)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .frames_per_half_bit (cfg.frames_per_half_bit),
    .step                (step),
    .buffer_start        (in_ch.buffer_start),
    .buffer_length       (in_ch.buffer_length),
    .level               (level)
  );

  assign in_ch.ready = !out_v_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  assign amp_ext    = SAMPLE_W'(cfg.amplitude);
  assign sample_nxt = level.level_high ? signed'(amp_ext) : signed'(SAMPLE_W'(0) - amp_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sample_r <= sample_nxt;
      high_r   <= level.level_high;
      sync_r   <= level.in_sync;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.sample     = sample_r;
  assign out_ch.level_high = high_r;
  assign out_ch.in_sync    = sync_r;

endmodule

### dv/tb_top.sv
// self-checking testbench of the manchester sync frame encoder unit
`timescale 1ns / 1ps
module tb_top;
  import msfe_pkg::*;

  localparam int HALF_MSG        = 2 * MESSAGE_BITS_DEF;
  localparam int HALF_CYCLE      = HALF_MSG + SYNC_LENGTH_DEF;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int LEN_CENTER      = 24576;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  localparam logic signed [SAMPLE_W-1:0] RESET_HIGH = 32'sd2126008811;
  localparam logic signed [SAMPLE_W-1:0] FULL_HIGH  = 32'sh7FFFFFFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       level_high;
    logic                       in_sync;
  } frame_out_t;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  start;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    frame_out_t            x;
  } step_row_t;

  localparam int DIR_N = 24;
  localparam step_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_FRAME, 4'd0, 1'b0, 31'h0000, 1'b1, '{RESET_HIGH, 1'b1, 1'b0}},
    '{ROW_FRAME, 4'd0, 1'b0, 31'hFFFF, 1'b1, '{RESET_HIGH, 1'b1, 1'b0}},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h6000, 1'b1, '{RESET_HIGH, 1'b1, 1'b0}},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h5FFF, 1'b1, '{RESET_HIGH, 1'b1, 1'b0}},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h6001, 1'b1, '{RESET_HIGH, 1'b1, 1'b0}},
    '{ROW_FRAME, 4'd0, 1'b0, 31'hAAAA, 1'b1, '{RESET_HIGH, 1'b1, 1'b0}},
    '{ROW_FRAME, 4'd0, 1'b0, 31'h5555, 1'b1, '{RESET_HIGH, 1'b1, 1'b0}},
    '{ROW_WRITE, CFG_FRAMES_PER_HALF_BIT, 1'b0, 31'h7FFFFC01, 1'b0, '0},
    '{ROW_WRITE, CFG_AMPLITUDE, 1'b0, 31'h7FFFFFFF, 1'b0, '0},
    '{ROW_WRITE, CFG_SPARE_LO, 1'b0, 31'h00000000, 1'b0, '0},
    '{ROW_WRITE, CFG_SPARE_HI, 1'b0, 31'h7FFFFFFF, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h6002, 1'b1, '{FULL_HIGH, 1'b1, 1'b0}},
    '{ROW_FRAME, 4'd0, 1'b0, 31'h0000, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b0, 31'hFFFF, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h5FFE, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b0, 31'h1234, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h6003, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b0, 31'h8000, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b0, 31'h0001, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h6000, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b0, 31'h7FFF, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b0, 31'hFFFE, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b1, 31'h5FFD, 1'b0, '0},
    '{ROW_FRAME, 4'd0, 1'b0, 31'h0F0F, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  msfe_in_if  in_ch ();
  msfe_out_if out_ch ();
  msfe_cfg_if cfg_ch ();

  manchester_sync_frame_encoder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // encoder model state
  logic [FPH_W-1:0]  enc_fph;
  logic [AMP_W-1:0]  enc_amp;
  logic [FC_W-1:0]   enc_frames;
  logic [HBC_W-1:0]  enc_half;
  logic [BP_W-1:0]   enc_bitpos;
  logic [WORD_W-1:0] enc_word;
  logic              enc_take_max;
  logic [LEN_W-1:0]  enc_min;
  logic [LEN_W-1:0]  enc_max;

  frame_out_t pending_frames[$];
  int         mismatch_cnt;
  int         stall_cycles;
  int         tx_idle_pct;
  int         rx_stall_pct;
  bit         hold_req;
  int         hold_left;
  int         buf_left;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  task automatic encode_frame(input logic start, input logic [LEN_W-1:0] len,
                              output frame_out_t res);
    logic             hi;
    logic             sync;
    logic [FPH_W-1:0] lim;
    logic [31:0]      mag;
    if (start) begin
      if (len > enc_max) enc_max = len;
      if (len < enc_min) enc_min = len;
    end
    if (enc_half < HALF_MSG) begin
      sync = 1'b0;
      hi   = (enc_half[0] == enc_word[enc_bitpos]);
    end else begin
      sync = 1'b1;
      hi   = SYNC_LEVELS[SYNC_IDX_W'(int'(enc_half) - HALF_MSG)];
    end
    mag = {1'b0, enc_amp};
    res.sample     = hi ? mag : 32'd0 - mag;
    res.level_high = hi;
    res.in_sync    = sync;
    lim = (enc_fph == '0) ? FPH_W'(1) : enc_fph;
    enc_frames = enc_frames + 1'b1;
    if (enc_frames >= lim || enc_frames == '0) begin
      enc_frames = '0;
      enc_half   = enc_half + 1'b1;
      if (!enc_half[0] && enc_bitpos != '0) enc_bitpos = enc_bitpos - 1'b1;
      if (enc_half >= HALF_CYCLE) begin
        enc_half     = '0;
        enc_bitpos   = BP_W'(MESSAGE_BITS_DEF - 1);
        enc_word     = enc_take_max ? WORD_W'(enc_max) : WORD_W'(enc_min);
        enc_take_max = ~enc_take_max;
      end
    end
  endtask

  task automatic send_frame(input logic start, input logic [LEN_W-1:0] len,
                            input logic typed, input frame_out_t typed_out);
    frame_out_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.buffer_start  = start;
    in_ch.buffer_length = len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_frame(start, len, predicted);
    pending_frames.push_back(typed ? typed_out : predicted);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_FRAMES_PER_HALF_BIT) enc_fph = data[FPH_W-1:0];
    else if (idx == CFG_AMPLITUDE) enc_amp = data[AMP_W-1:0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_len(input int spread);
    int v;
    if (spread < 0) return LEN_W'($urandom);
    v = LEN_CENTER + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return LEN_W'(v);
  endfunction

  // host buffers: a start carrying the length, then its frames, sometimes cut short
  task automatic next_buffer_frame(input int spread, output logic start,
                                   output logic [LEN_W-1:0] len);
    if (buf_left == 0 || $urandom_range(15) == 0) begin
      start    = 1'b1;
      len      = pick_len(spread);
      buf_left = (len != 0 && len < 24) ? int'(len) - 1 : int'($urandom_range(23));
    end else begin
      start    = 1'b0;
      len      = LEN_W'($urandom);
      buf_left = buf_left - 1;
    end
  endtask

  task automatic run_phase(input int fph, input bit amp_rand, input logic [AMP_W-1:0] amp,
                           input int tx_pct, input int rx_pct, input int n_frames,
                           input int spread, input bit pressure);
    logic [CFG_DATA_W-1:0] data;
    logic                  start;
    logic [LEN_W-1:0]      len;
    drain_results();
    data = CFG_DATA_W'($urandom);
    data[FPH_W-1:0] = FPH_W'(fph);
    write_reg(CFG_FRAMES_PER_HALF_BIT, data);
    write_reg(CFG_AMPLITUDE, amp_rand ? CFG_DATA_W'($urandom) : CFG_DATA_W'(amp));
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_frames; i++) begin
      if (pressure && i == n_frames / 4) hold_req = 1'b1;
      next_buffer_frame(spread, start, len);
      send_frame(start, len, 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    frame_out_t got;
    frame_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sample, out_ch.level_high, out_ch.in_sync};
        if (pending_frames.size() == 0) begin
          flag_mismatch("result with nothing pending");
        end else begin
          want = pending_frames.pop_front();
          if (got.sample !== want.sample)
            flag_mismatch($sformatf("sample got %0d want %0d", got.sample, want.sample));
          if (got.level_high !== want.level_high)
            flag_mismatch($sformatf("level_high got %b want %b", got.level_high,
                                    want.level_high));
          if (got.in_sync !== want.in_sync)
            flag_mismatch($sformatf("in_sync got %b want %b", got.in_sync, want.in_sync));
        end
      end
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.buffer_start  = 1'b0;
    in_ch.buffer_length = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_FRAMES_PER_HALF_BIT;
    cfg_ch.data         = '0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    hold_req            = 1'b0;
    hold_left           = 0;
    buf_left            = 0;
    mismatch_cnt        = 0;
    stall_cycles        = 0;
    enc_fph             = FPH_RESET;
    enc_amp             = AMP_RESET;
    enc_frames          = '0;
    enc_half            = '0;
    enc_bitpos          = '0;
    enc_word            = '0;
    enc_take_max        = 1'b0;
    enc_min             = MIN_RESET;
    enc_max             = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value);
      end else begin
        send_frame(DIR_ROWS[i].start, DIR_ROWS[i].value[LEN_W-1:0], DIR_ROWS[i].typed,
                   DIR_ROWS[i].x);
      end
    end

    // lengths widen phase by phase so the sent words keep changing
    run_phase(1,    1'b0, 31'h7FFFFFFF, 0,  0,  300, 16,    1'b0);
    run_phase(0,    1'b0, 31'h0,        68, 0,  150, 64,    1'b0);
    run_phase(2,    1'b1, 31'h0,        0,  68, 300, 256,   1'b0);
    run_phase(1023, 1'b0, 31'h1,        21, 21, 60,  1024,  1'b0);
    // shorter half-bit while the counter is past it
    run_phase(3,    1'b1, 31'h0,        0,  0,  300, 4096,  1'b1);
    run_phase(1,    1'b1, 31'h0,        21, 21, 400, 40000, 1'b0);
    run_phase(5,    1'b0, 31'h7FFFFFFF, 68, 0,  200, -1,    1'b0);
    run_phase(40,   1'b1, 31'h0,        0,  68, 150, -1,    1'b0);

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
